@@ design/qcc_pkg.sv @@
// ----------------------------------------------------------------------------
// qcc_pkg
// Shared widths, constants, register codes and types of the four-channel
// centroid unit.
// ----------------------------------------------------------------------------
package qcc_pkg;

	localparam int N_CH           = 4;
	localparam int RAW_W          = 12;
	localparam int CFG_W          = 12;
	localparam int COR_W          = RAW_W + 1;
	localparam int E_W            = 14;
	localparam int NUM_W          = E_W + 1;
	localparam int POS_W          = 12;
	localparam int OVERFLOW_LIMIT = 4095;
	localparam int POS_SCALE      = 1198;
	localparam int LIM_W          = 17;
	localparam int PS_W           = $clog2(POS_SCALE + 1);
	localparam int DEN_W          = E_W;
	localparam int QW             = DEN_W + PS_W;
	localparam int P_MAX          = 2047;
	localparam int P_MIN_MAG      = 2048;

	localparam int IN_W           = 48;
	localparam int OUT_W          = 56;

	localparam int QDEPTH         = 4;
	localparam int QPTR_W         = $clog2(QDEPTH);

	localparam int ADDR_W         = 5;
	localparam int DATA_W         = 32;

	typedef enum logic [2:0] {
		REG_PED0,
		REG_PED1,
		REG_PED2,
		REG_PED3,
		REG_THR0,
		REG_THR1,
		REG_THR2,
		REG_THR3
	} reg_idx_t;

	typedef struct packed {
		logic [N_CH-1:0][CFG_W-1:0] ped;
		logic [N_CH-1:0][CFG_W-1:0] thr;
	} cfg_t;

	typedef struct packed {
		logic [E_W-1:0]          energy_raw;
		logic [E_W-1:0]          energy_corr;
		logic                    raw_ok;
		logic                    corr_ok;
		logic                    pos_valid;
		logic signed [NUM_W-1:0] num_x;
		logic signed [NUM_W-1:0] num_y;
	} ev_t;

endpackage

@@ design/qcc_regs.sv @@
// ----------------------------------------------------------------------------
// qcc_regs
// APB register file holding the pedestal and threshold of each channel.
// ----------------------------------------------------------------------------
module qcc_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [qcc_pkg::ADDR_W-1:0] paddr,
	input  logic [qcc_pkg::DATA_W-1:0] pwdata,
	output logic [qcc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output qcc_pkg::cfg_t              cfg
);
	import qcc_pkg::*;

	logic [N_CH-1:0][CFG_W-1:0] ped_q;
	logic [N_CH-1:0][CFG_W-1:0] thr_q;
	reg_idx_t                   idx;
	logic                       wr;
	logic [CFG_W-1:0]           rd_val;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ped_q <= '0;
			thr_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_PED0: ped_q[0] <= pwdata[CFG_W-1:0];
				REG_PED1: ped_q[1] <= pwdata[CFG_W-1:0];
				REG_PED2: ped_q[2] <= pwdata[CFG_W-1:0];
				REG_PED3: ped_q[3] <= pwdata[CFG_W-1:0];
				REG_THR0: thr_q[0] <= pwdata[CFG_W-1:0];
				REG_THR1: thr_q[1] <= pwdata[CFG_W-1:0];
				REG_THR2: thr_q[2] <= pwdata[CFG_W-1:0];
				REG_THR3: thr_q[3] <= pwdata[CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PED0: rd_val = ped_q[0];
			REG_PED1: rd_val = ped_q[1];
			REG_PED2: rd_val = ped_q[2];
			REG_PED3: rd_val = ped_q[3];
			REG_THR0: rd_val = thr_q[0];
			REG_THR1: rd_val = thr_q[1];
			REG_THR2: rd_val = thr_q[2];
			REG_THR3: rd_val = thr_q[3];
		endcase
	end

	assign prdata  = {{(DATA_W-CFG_W){1'b0}}, rd_val};
	assign cfg.ped = ped_q;
	assign cfg.thr = thr_q;

endmodule

@@ design/qcc_front.sv @@
// ----------------------------------------------------------------------------
// qcc_front
// Accept an event, subtract pedestals, form sums, validity flags and
// centroid numerators, and hand the result to the queue.
// ----------------------------------------------------------------------------
module qcc_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  qcc_pkg::cfg_t            cfg,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [qcc_pkg::IN_W-1:0] s_tdata,
	output logic                     push,
	output qcc_pkg::ev_t             push_data,
	input  logic                     q_full
);
	import qcc_pkg::*;

	logic                          v_s1;
	ev_t                           ev_s1;
	ev_t                           ev_d;
	logic [N_CH-1:0][RAW_W-1:0]    raw;
	logic signed [COR_W-1:0]       c [N_CH];
	logic signed [NUM_W-1:0]       ce [N_CH];
	logic [E_W-1:0]                sraw;
	logic signed [NUM_W-1:0]       scorr;
	logic                          rok;
	logic                          cok;

	assign raw = s_tdata[N_CH*RAW_W-1:0];

	always_comb begin
		sraw  = '0;
		scorr = '0;
		rok   = 1'b1;
		cok   = 1'b1;
		for (int i = 0; i < N_CH; i++) begin
			if (raw[i] > cfg.thr[i]) begin
				c[i] = $signed({1'b0, raw[i]}) - $signed({1'b0, cfg.ped[i]});
			end else begin
				c[i] = '0;
			end
			ce[i] = NUM_W'(c[i]);
			sraw  = sraw + E_W'(raw[i]);
			scorr = scorr + ce[i];
			if (raw[i] == '0 || LIM_W'(raw[i]) >= LIM_W'(OVERFLOW_LIMIT)) begin
				rok = 1'b0;
			end
			if (c[i][COR_W-1] || c[i] == '0
				|| LIM_W'(c[i][COR_W-2:0]) >= LIM_W'(OVERFLOW_LIMIT)) begin
				cok = 1'b0;
			end
		end
		ev_d.energy_raw  = sraw;
		ev_d.energy_corr = scorr[NUM_W-1] ? '0 : scorr[E_W-1:0];
		ev_d.raw_ok      = rok;
		ev_d.corr_ok     = cok;
		ev_d.pos_valid   = rok && cok;
		if (rok && cok) begin
			ev_d.num_x = -ce[0] + ce[1] + ce[2] - ce[3];
			ev_d.num_y =  ce[0] + ce[1] - ce[2] - ce[3];
		end else begin
			ev_d.num_x = '0;
			ev_d.num_y = '0;
		end
	end

	assign push      = v_s1 && !q_full;
	assign s_tready  = !v_s1 || !q_full;
	assign push_data = ev_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ev_s1 <= ev_d;
		end
	end

endmodule

@@ design/qcc_queue.sv @@
// ----------------------------------------------------------------------------
// qcc_queue
// Short register queue between the classifying front and the divider back.
// ----------------------------------------------------------------------------
module qcc_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  qcc_pkg::ev_t push_data,
	output logic         full,
	input  logic         pop,
	output qcc_pkg::ev_t pop_data,
	output logic         not_empty
);
	import qcc_pkg::*;

	ev_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full      = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/qcc_back.sv @@
// ----------------------------------------------------------------------------
// qcc_back
// Scale the numerators, divide by the corrected sum in a one-bit-per-stage
// restoring pipeline, saturate and drive the result stream.
// ----------------------------------------------------------------------------
module qcc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  qcc_pkg::ev_t              ev,
	input  logic                      ev_valid,
	output logic                      ev_pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [qcc_pkg::OUT_W-1:0] m_tdata
);
	import qcc_pkg::*;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QW-1:0]    dq;
	} lane_t;

	typedef struct packed {
		lane_t            lx;
		lane_t            ly;
		logic             neg_x;
		logic             neg_y;
		logic [DEN_W-1:0] den;
		logic [E_W-1:0]   energy_raw;
		logic [E_W-1:0]   energy_corr;
		logic             raw_ok;
		logic             corr_ok;
		logic             pos_valid;
	} bk_t;

	function automatic lane_t div_step(lane_t a, logic [DEN_W-1:0] den);
		logic [DEN_W:0] t;
		lane_t          r;
		t    = {a.rem, a.dq[QW-1]};
		r.dq = {a.dq[QW-2:0], 1'b0};
		if (t >= {1'b0, den}) begin
			r.rem   = DEN_W'(t - {1'b0, den});
			r.dq[0] = 1'b1;
		end else begin
			r.rem = t[DEN_W-1:0];
		end
		return r;
	endfunction

	function automatic bk_t div_stage(bk_t a);
		bk_t r;
		r    = a;
		r.lx = div_step(a.lx, a.den);
		r.ly = div_step(a.ly, a.den);
		return r;
	endfunction

	function automatic logic [POS_W-1:0] sat_pos(logic [QW-1:0] q, logic neg);
		logic [POS_W-1:0] v;
		if (neg) begin
			if (q > QW'(P_MIN_MAG)) begin
				v = POS_W'(P_MIN_MAG);
			end else begin
				v = ~q[POS_W-1:0] + 1'b1;
			end
		end else begin
			if (q > QW'(P_MAX)) begin
				v = POS_W'(P_MAX);
			end else begin
				v = q[POS_W-1:0];
			end
		end
		return v;
	endfunction

	bk_t              st_s [QW+1];
	logic [QW:0]      vld_s;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             adv;
	logic [NUM_W-1:0] ax;
	logic [NUM_W-1:0] ay;
	bk_t              ld;
	bk_t              fin;
	logic [POS_W-1:0] x_pos;
	logic [POS_W-1:0] y_pos;

	assign adv    = !out_valid_q || m_tready;
	assign ev_pop = ev_valid && adv;

	always_comb begin
		ax             = ev.num_x[NUM_W-1] ? NUM_W'(-ev.num_x) : NUM_W'(ev.num_x);
		ay             = ev.num_y[NUM_W-1] ? NUM_W'(-ev.num_y) : NUM_W'(ev.num_y);
		ld.lx.rem      = '0;
		ld.ly.rem      = '0;
		ld.lx.dq       = QW'(ax[DEN_W-1:0]) * QW'(POS_SCALE);
		ld.ly.dq       = QW'(ay[DEN_W-1:0]) * QW'(POS_SCALE);
		ld.neg_x       = ev.num_x[NUM_W-1];
		ld.neg_y       = ev.num_y[NUM_W-1];
		ld.den         = ev.energy_corr;
		ld.energy_raw  = ev.energy_raw;
		ld.energy_corr = ev.energy_corr;
		ld.raw_ok      = ev.raw_ok;
		ld.corr_ok     = ev.corr_ok;
		ld.pos_valid   = ev.pos_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[QW-1:0], ev_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0] <= ld;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[k] <= div_stage(st_s[k-1]);
			end
		end
	end

	assign fin   = st_s[QW];
	assign x_pos = fin.pos_valid ? sat_pos(fin.lx.dq, fin.neg_x) : '0;
	assign y_pos = fin.pos_valid ? sat_pos(fin.ly.dq, fin.neg_y) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= OUT_W'({y_pos, x_pos, fin.pos_valid, fin.corr_ok, fin.raw_ok,
				fin.energy_corr, fin.energy_raw});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ design/quad_channel_centroid_unit.sv @@
// ----------------------------------------------------------------------------
// quad_channel_centroid_unit
// Pedestal subtraction and center-of-gravity position of a four-corner
// detector event.
//
//   channel   dir  fields (low bit up)
//   s_*       in   tdata: raw_ch0 raw_ch1 raw_ch2 raw_ch3 (12 b each)
//   m_*       out  tdata: energy_raw(14) energy_corr(14) raw_ok corr_ok
//                         pos_valid x_pos(12) y_pos(12), bit 55 zero
//   apb       cfg  ped_ch0..3 at 0x00..0x0c, thresh_ch0..3 at 0x10..0x1c
//
// One event per cycle while m_tready is high. An event passes the front register,
// the queue, and the one-bit-per-stage divider and output register of the back part.
// Reset clears pipeline valids, queue pointers and registers; no clearing pass.
// m_tready low freezes the back part; the four-entry queue absorbs events
// until the front stalls and drops s_tready.
// ----------------------------------------------------------------------------
module quad_channel_centroid_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [qcc_pkg::IN_W-1:0]   s_tdata,  // raw_ch0, raw_ch1, raw_ch2, raw_ch3
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [qcc_pkg::OUT_W-1:0]  m_tdata,  // energy_raw, energy_corr, raw_ok,
	                                             // corr_ok, pos_valid, x_pos, y_pos
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [qcc_pkg::ADDR_W-1:0] paddr,
	input  logic [qcc_pkg::DATA_W-1:0] pwdata,
	output logic [qcc_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import qcc_pkg::*;

	cfg_t cfg;
	ev_t  push_data;
	ev_t  pop_data;
	logic push;
	logic pop;
	logic q_full;
	logic q_not_empty;

	qcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	qcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty)
	);

	qcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev       (pop_data),
		.ev_valid (q_not_empty),
		.ev_pop   (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ design/qcc_checker.sv @@
// ----------------------------------------------------------------------------
// qcc_checker
// Port-level checks of the centroid unit, bound to the top level.
// ----------------------------------------------------------------------------
module qcc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [qcc_pkg::OUT_W-1:0]  m_tdata,
	input logic                       pready
);
	import qcc_pkg::*;

	localparam int B_ROK = 2 * E_W;
	localparam int B_COK = B_ROK + 1;
	localparam int B_PV  = B_ROK + 2;
	localparam int B_X   = B_ROK + 3;

	a_hold_valid : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_pos_flags : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[B_PV] |-> m_tdata[B_ROK] && m_tdata[B_COK])
		else $error("pos_valid without both checks");

	a_pos_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[B_PV] |-> m_tdata[B_X+2*POS_W-1:B_X] == '0)
		else $error("position nonzero while not valid");

	a_pready : assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind quad_channel_centroid_unit qcc_checker u_qcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
